### hdl/vcg_pkg.sv
package vcg_pkg;

    localparam int unsigned DIM_MAX  = 64;
    localparam int unsigned CFG_AW   = 3;
    localparam int unsigned CFG_DW   = 16;
    localparam int unsigned DIM_W    = 7;
    localparam int unsigned POS_W    = 6;
    localparam int unsigned SMP_W    = 16;
    localparam int unsigned SP_W     = 16;
    localparam int unsigned RUN_W    = 18;
    localparam int unsigned QUO_W    = 32;
    localparam int unsigned GRAD_W   = 33;
    localparam int unsigned VTX_W    = 3;
    localparam int unsigned IN_DW    = 40;
    localparam int unsigned OUT_DW   = 104;
    localparam int unsigned OUT_USED = VTX_W + 3 * GRAD_W;

    localparam logic [CFG_AW-1:0] CFG_DIM_X = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_DIM_Y = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_DIM_Z = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_SP_X  = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_SP_Y  = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_SP_Z  = 3'd5;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [VTX_W-1:0] VTX_LAST = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RD_LO,
        ST_RD_HI,
        ST_DIFF,
        ST_DIV,
        ST_EMIT,
        ST_ERR
    } t_state;

    typedef struct packed {
        logic              rd_en;
        logic              sel_hi;
        logic              cap_lo;
        logic              diff_ld;
        logic              div_step;
        logic              div_last;
        logic              load_out;
        logic              load_err;
        logic [VTX_W-1:0]  vertex;
        logic [1:0]        axis;
    } t_ctl_cmd;

    typedef struct packed {
        logic in_range;
        logic out_free;
    } t_ctl_sts;

    // cube vertex offsets, returned as {dz, dy, dx}
    function automatic logic [2:0] corner_off(input logic [VTX_W-1:0] v);
        logic [2:0] o;
        case (v)
            3'd0:    o = 3'b000;
            3'd1:    o = 3'b001;
            3'd2:    o = 3'b011;
            3'd3:    o = 3'b010;
            3'd4:    o = 3'b100;
            3'd5:    o = 3'b101;
            3'd6:    o = 3'b111;
            default: o = 3'b110;
        endcase
        return o;
    endfunction

endpackage

### hdl/vcg_ctrl.sv
module vcg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_s_tuser,
    output logic              o_s_tready,
    input  vcg_pkg::t_ctl_sts i_sts,
    output vcg_pkg::t_ctl_cmd o_cmd
);

    vcg_pkg::t_state r_state, n_state;
    logic [vcg_pkg::VTX_W-1:0] r_vertex, n_vertex;
    logic [1:0]                r_axis, n_axis;
    logic [4:0]                r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= vcg_pkg::ST_IDLE;
            r_vertex <= '0;
            r_axis   <= vcg_pkg::AXIS_X;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_vertex <= n_vertex;
            r_axis   <= n_axis;
            r_cnt    <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_vertex   = r_vertex;
        n_axis     = r_axis;
        n_cnt      = r_cnt;
        o_s_tready = 1'b0;
        o_cmd      = '0;
        o_cmd.vertex = r_vertex;
        o_cmd.axis   = r_axis;
        unique case (r_state)
            vcg_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid && i_s_tuser == vcg_pkg::CMD_QUERY) begin
                    n_state  = vcg_pkg::ST_CHECK;
                    n_vertex = '0;
                    n_axis   = vcg_pkg::AXIS_X;
                end
            end
            vcg_pkg::ST_CHECK: begin
                n_state = i_sts.in_range ? vcg_pkg::ST_RD_LO : vcg_pkg::ST_ERR;
            end
            vcg_pkg::ST_RD_LO: begin
                o_cmd.rd_en = 1'b1;
                n_state     = vcg_pkg::ST_RD_HI;
            end
            vcg_pkg::ST_RD_HI: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.sel_hi = 1'b1;
                o_cmd.cap_lo = 1'b1;
                n_state      = vcg_pkg::ST_DIFF;
            end
            vcg_pkg::ST_DIFF: begin
                o_cmd.diff_ld = 1'b1;
                n_cnt         = '0;
                n_state       = vcg_pkg::ST_DIV;
            end
            vcg_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    o_cmd.div_last = 1'b1;
                    if (r_axis == vcg_pkg::AXIS_Z) begin
                        n_state = vcg_pkg::ST_EMIT;
                    end else begin
                        n_axis  = r_axis + 2'd1;
                        n_state = vcg_pkg::ST_RD_LO;
                    end
                end
            end
            vcg_pkg::ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_axis         = vcg_pkg::AXIS_X;
                    if (r_vertex == vcg_pkg::VTX_LAST) begin
                        n_state = vcg_pkg::ST_IDLE;
                    end else begin
                        n_vertex = r_vertex + 3'd1;
                        n_state  = vcg_pkg::ST_RD_LO;
                    end
                end
            end
            vcg_pkg::ST_ERR: begin
                if (i_sts.out_free) begin
                    o_cmd.load_err = 1'b1;
                    n_state        = vcg_pkg::ST_IDLE;
                end
            end
            default: n_state = vcg_pkg::ST_IDLE;
        endcase
    end

endmodule

### hdl/vcg_dpath.sv
module vcg_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [vcg_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [vcg_pkg::CFG_DW-1:0]  i_cfg_wdata,
    input  logic                        i_accept,
    input  logic                        i_cmd,
    input  logic [vcg_pkg::IN_DW-1:0]   i_in_data,
    input  vcg_pkg::t_ctl_cmd           i_cmd_bus,
    output vcg_pkg::t_ctl_sts           o_sts,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [vcg_pkg::OUT_DW-1:0]  o_m_tdata,
    output logic                        o_m_tlast,
    output logic                        o_m_tuser
);

    localparam int unsigned LG = (vcg_pkg::DIM_MAX > 1) ? $clog2(vcg_pkg::DIM_MAX) : 1;
    localparam int unsigned AW = 3 * LG;
    localparam int unsigned DW = vcg_pkg::DIM_W;

    // configuration
    logic [DW-1:0]              r_dim_x, r_dim_y, r_dim_z;
    logic [vcg_pkg::SP_W-1:0]   r_sp_x, r_sp_y, r_sp_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_x <= 7'd64;
            r_dim_y <= 7'd64;
            r_dim_z <= 7'd64;
            r_sp_x  <= 16'd256;
            r_sp_y  <= 16'd256;
            r_sp_z  <= 16'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                vcg_pkg::CFG_DIM_X: r_dim_x <= i_cfg_wdata[DW-1:0];
                vcg_pkg::CFG_DIM_Y: r_dim_y <= i_cfg_wdata[DW-1:0];
                vcg_pkg::CFG_DIM_Z: r_dim_z <= i_cfg_wdata[DW-1:0];
                vcg_pkg::CFG_SP_X:  r_sp_x  <= i_cfg_wdata;
                vcg_pkg::CFG_SP_Y:  r_sp_y  <= i_cfg_wdata;
                vcg_pkg::CFG_SP_Z:  r_sp_z  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    function automatic logic [DW-1:0] eff_dim(input logic [DW-1:0] d);
        return (int'(d) > int'(vcg_pkg::DIM_MAX)) ? DW'(vcg_pkg::DIM_MAX) : d;
    endfunction

    function automatic logic [vcg_pkg::SP_W-1:0] eff_sp(input logic [vcg_pkg::SP_W-1:0] s);
        return (s == '0) ? 16'd1 : s;
    endfunction

    logic [DW-1:0] dx, dy, dz;
    assign dx = eff_dim(r_dim_x);
    assign dy = eff_dim(r_dim_y);
    assign dz = eff_dim(r_dim_z);

    // input fields
    logic [vcg_pkg::POS_W-1:0] in_x, in_y, in_z;
    logic [vcg_pkg::SMP_W-1:0] in_smp;
    assign in_x   = i_in_data[5:0];
    assign in_y   = i_in_data[11:6];
    assign in_z   = i_in_data[17:12];
    assign in_smp = i_in_data[33:18];

    // query corner
    logic [vcg_pkg::POS_W-1:0] r_px, r_py, r_pz;
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_px <= in_x;
            r_py <= in_y;
            r_pz <= in_z;
        end
    end

    // corner within [0, dim-2] on every axis
    assign o_sts.in_range = (dx >= 7'd2) && (dy >= 7'd2) && (dz >= 7'd2)
                         && ({1'b0, r_px} + 7'd2 <= dx)
                         && ({1'b0, r_py} + 7'd2 <= dy)
                         && ({1'b0, r_pz} + 7'd2 <= dz);

    // vertex coordinates and neighbor selection on the active axis
    logic [2:0]    off;
    logic [DW-1:0] cx, cy, cz, p, d, p_lo, p_hi, p_sel;
    logic [vcg_pkg::SP_W-1:0]  sp;
    logic [vcg_pkg::RUN_W-1:0] run;
    logic [DW-1:0] ax, ay, az;
    logic          edge_plane;

    always_comb begin
        off = vcg_pkg::corner_off(i_cmd_bus.vertex);
        cx  = {1'b0, r_px} + {6'd0, off[0]};
        cy  = {1'b0, r_py} + {6'd0, off[1]};
        cz  = {1'b0, r_pz} + {6'd0, off[2]};
        case (i_cmd_bus.axis)
            vcg_pkg::AXIS_X: begin p = cx; d = dx; sp = eff_sp(r_sp_x); end
            vcg_pkg::AXIS_Y: begin p = cy; d = dy; sp = eff_sp(r_sp_y); end
            default:         begin p = cz; d = dz; sp = eff_sp(r_sp_z); end
        endcase
        p_lo  = (p == '0) ? p : p - 7'd1;
        p_hi  = (p == d - 7'd1) ? p : p + 7'd1;
        p_sel = i_cmd_bus.sel_hi ? p_hi : p_lo;
        edge_plane = (p == '0) || (p == d - 7'd1);
        run = edge_plane ? {2'b00, sp} : {1'b0, sp, 1'b0};
        ax  = (i_cmd_bus.axis == vcg_pkg::AXIS_X) ? p_sel : cx;
        ay  = (i_cmd_bus.axis == vcg_pkg::AXIS_Y) ? p_sel : cy;
        az  = (i_cmd_bus.axis == vcg_pkg::AXIS_Z) ? p_sel : cz;
    end

    // sample store
    logic [vcg_pkg::SMP_W-1:0] mem [0:(1 << AW) - 1];
    logic [vcg_pkg::SMP_W-1:0] r_rd, r_lo;
    logic [AW-1:0] wr_addr, rd_addr;
    logic          wr_ok;

    assign wr_addr = {LG'(in_z), LG'(in_y), LG'(in_x)};
    assign rd_addr = {LG'(az), LG'(ay), LG'(ax)};
    assign wr_ok   = i_accept && (i_cmd == vcg_pkg::CMD_WRITE)
                  && ({1'b0, in_x} < dx) && ({1'b0, in_y} < dy) && ({1'b0, in_z} < dz);

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            mem[wr_addr] <= in_smp;
        end
        if (i_cmd_bus.rd_en) begin
            r_rd <= mem[rd_addr];
        end
        if (i_cmd_bus.cap_lo) begin
            r_lo <= r_rd;
        end
    end

    // restoring divider, one quotient bit a cycle
    logic signed [16:0]          diff;
    logic [15:0]                 mag;
    logic                        r_sign;
    logic [vcg_pkg::RUN_W-1:0]   r_run;
    logic [16:0]                 r_rem;
    logic [vcg_pkg::QUO_W-1:0]   r_num;
    logic [17:0]                 trial;
    logic                        ge;
    logic [16:0]                 n_rem;
    logic [vcg_pkg::QUO_W-1:0]   n_num;
    logic [vcg_pkg::GRAD_W-1:0]  q_ext, grad;

    always_comb begin
        diff  = $signed({r_lo[15], r_lo}) - $signed({r_rd[15], r_rd});
        mag   = diff[16] ? 16'(-diff) : diff[15:0];
        trial = {r_rem, r_num[vcg_pkg::QUO_W-1]};
        ge    = (trial >= r_run);
        n_rem = ge ? 17'(trial - r_run) : trial[16:0];
        n_num = {r_num[vcg_pkg::QUO_W-2:0], ge};
        q_ext = {1'b0, n_num};
        grad  = r_sign ? -q_ext : q_ext;
    end

    logic [vcg_pkg::GRAD_W-1:0] r_gx, r_gy, r_gz;

    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.diff_ld) begin
            r_sign <= diff[16];
            r_run  <= run;
            r_rem  <= '0;
            r_num  <= {mag, 16'd0};
        end else if (i_cmd_bus.div_step) begin
            r_rem <= n_rem;
            r_num <= n_num;
        end
        if (i_cmd_bus.div_last) begin
            case (i_cmd_bus.axis)
                vcg_pkg::AXIS_X: r_gx <= grad;
                vcg_pkg::AXIS_Y: r_gy <= grad;
                default:         r_gz <= grad;
            endcase
        end
    end

    // output register
    logic r_valid;
    assign o_sts.out_free = !r_valid || i_m_tready;
    assign o_m_tvalid     = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd_bus.load_out || i_cmd_bus.load_err) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.load_out) begin
            o_m_tdata <= {(vcg_pkg::OUT_DW - vcg_pkg::OUT_USED)'(0),
                          r_gz, r_gy, r_gx, i_cmd_bus.vertex};
            o_m_tlast <= (i_cmd_bus.vertex == vcg_pkg::VTX_LAST);
            o_m_tuser <= 1'b0;
        end else if (i_cmd_bus.load_err) begin
            o_m_tdata <= '0;
            o_m_tlast <= 1'b1;
            o_m_tuser <= 1'b1;
        end
    end

endmodule

### hdl/volume_cube_gradient.sv
// Volume gradient engine: stores a scalar volume and returns central-difference
// gradients (one-sided on the edge planes) for the eight vertices of a queried cube.
//
// Input stream (s side): tuser = cmd (0 write one sample, 1 query a cube).
//   tdata = pos_x, pos_y, pos_z, sample. A write gives no result; a write
//   outside the active dimensions is dropped.
// Output stream (m side): tdata = vertex, grad_x, grad_y, grad_z (8 fraction
//   bits), tuser = range_error, tlast = final result of a query.
// Config port: write enable, register index, data; write only while idle.
//
// Query: the work is set by one shared radix-2 divider that gives a quotient bit a
//   cycle and by two reads of the sample memory per gradient component.
//   No new request is taken until a query is done; an out-of-range query
//   answers with one error result.
// Reset (synchronous, active low): dimensions return to 64, spacings to 1.0,
//   the output register empties; the sample memory is not cleared.
// Stall: a finished result waits in the output register; the next vertex is
//   computed meanwhile and held until the register frees.
module volume_cube_gradient (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic [vcg_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [vcg_pkg::CFG_DW-1:0]  i_cfg_wdata,
    // request stream
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [vcg_pkg::IN_DW-1:0]   i_s_tdata,   // pos_x[5:0] pos_y[11:6] pos_z[17:12] sample[33:18]
    input  logic                        i_s_tuser,   // cmd
    // result stream
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [vcg_pkg::OUT_DW-1:0]  o_m_tdata,   // vertex[2:0] grad_x[35:3] grad_y[68:36] grad_z[101:69]
    output logic                        o_m_tlast,   // last
    output logic                        o_m_tuser    // range_error
);

    vcg_pkg::t_ctl_cmd cmd;
    vcg_pkg::t_ctl_sts sts;
    logic              accept;

    // accept a request only while the controller is idle
    assign accept = i_s_tvalid && o_s_tready;

    vcg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tuser  (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    vcg_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_cmd       (i_s_tuser),
        .i_in_data   (i_s_tdata),
        .i_cmd_bus   (cmd),
        .o_sts       (sts),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

### hdl/vcg_checker.sv
module vcg_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_m_tvalid,
    input logic                        i_m_tready,
    input logic [vcg_pkg::OUT_DW-1:0]  o_m_tdata,
    input logic                        o_m_tlast,
    input logic                        o_m_tuser
);

    // error result is a single, final, zero result
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tlast && o_m_tdata == '0))
        else $error("error result not single zero result");

    // last marks vertex 7 of a good query
    a_last_vtx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tlast == (o_m_tdata[2:0] == 3'd7)))
        else $error("last flag and vertex disagree");

    // a vertex taken mid-query is followed by a different vertex
    a_vtx_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && !o_m_tlast) ##1 o_m_tvalid
        |-> (o_m_tdata[2:0] == $past(o_m_tdata[2:0]) + 3'd1 || $past(o_m_tvalid) == 1'b0
             || !$past(i_m_tready) || o_m_tdata[2:0] != $past(o_m_tdata[2:0])))
        else $error("vertex order broken");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
        (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast) && $stable(o_m_tuser)))
        else $error("stalled result changed");

endmodule

bind volume_cube_gradient vcg_checker u_vcg_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);
